// ===== rtl/drwp_pkg.sv =====
// Types and constants shared by the digitizer readout word parser modules.
package drwp_pkg;

  localparam int WORD_W     = 32;
  localparam int ROC_W      = 8;
  localparam int EVT_W      = 64;
  localparam int IDX_W      = 32;
  localparam int SLOT_W     = 5;
  localparam int MOD_W      = 4;
  localparam int HALF_W     = 24;
  localparam int TIME_W     = 48;
  localparam int DESC_W     = 9;
  localparam int COUNT_W    = 33;
  localparam int SUM_W      = 35;
  localparam int NSB_HI_W   = 28;
  localparam int PULSE_W    = 42;
  localparam int TYPE_W     = 5;
  localparam int ACC_CNT_W  = 4;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 296;

  typedef enum logic [1:0] {
    KIND_INFO         = 2'd0,
    KIND_ACC          = 2'd1,
    KIND_TRAILER_SLOT = 2'd2,
    KIND_EVENT_SLOT   = 2'd3
  } kind_t;

  localparam logic [TYPE_W-1:0] TYPE_BLOCK_HEADER  = 5'd0;
  localparam logic [TYPE_W-1:0] TYPE_BLOCK_TRAILER = 5'd1;
  localparam logic [TYPE_W-1:0] TYPE_EVENT_HEADER  = 5'd2;
  localparam logic [TYPE_W-1:0] TYPE_TRIG_TIME     = 5'd3;
  localparam logic [TYPE_W-1:0] TYPE_ACCUM         = 5'd10;
  localparam logic [TYPE_W-1:0] TYPE_NONE          = 5'd16;

  localparam logic [ACC_CNT_W-1:0] ACC_IDLE = 4'd0;
  localparam logic [ACC_CNT_W-1:0] ACC_LAST = 4'd10;

  typedef struct packed {
    kind_t               kind;
    logic [EVT_W-1:0]    evt_num;
    logic [ROC_W-1:0]    source_roc;
    logic [SLOT_W-1:0]   slot;
    logic [MOD_W-1:0]    mod_code;
    logic [TIME_W-1:0]   time_first;
    logic [TIME_W-1:0]   time_second;
    logic [DESC_W-1:0]   acc_descriptor;
    logic [COUNT_W-1:0]  sample_count;
    logic [SUM_W-1:0]    sample_sum;
    logic [PULSE_W-1:0]  pulse_counts;
  } result_t;

  typedef struct packed {
    logic                 halted;
    logic [ACC_CNT_W-1:0] acc_count;
  } status_t;

endpackage

// ===== rtl/drwp_parser.sv =====
// Per-word decoder and per-bank state registers of the readout word parser.
module drwp_parser import drwp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [WORD_W-1:0] word,
  input  logic              bank_start,
  input  logic [ROC_W-1:0]  roc_id,
  input  logic [EVT_W-1:0]  first_event,
  output logic              res_valid,
  output result_t           res,
  output status_t           status
);

  logic [SLOT_W-1:0]    header_slot,    header_slot_next;
  logic [MOD_W-1:0]     header_module,  header_module_next;
  logic [EVT_W-1:0]     base_event,     base_event_next;
  logic [IDX_W-1:0]     evt_offset,     evt_offset_next;
  logic [EVT_W-1:0]     current_event,  current_event_next;
  logic [ROC_W-1:0]     latched_roc,    latched_roc_next;
  logic [HALF_W-1:0]    trig_time_low,  trig_time_low_next;
  logic [HALF_W-1:0]    trig_time_high, trig_time_high_next;
  logic [TYPE_W-1:0]    previous_type,  previous_type_next;
  logic [ACC_CNT_W-1:0] acc_count,      acc_count_next;
  logic                 halted,         halted_next;

  logic [DESC_W-1:0]    acc_desc,       acc_desc_next;
  logic [TIME_W-1:0]    acc_time_first, acc_time_first_next;
  logic [TIME_W-1:0]    acc_time_second, acc_time_second_next;
  logic [COUNT_W-1:0]   acc_samples,    acc_samples_next;
  logic [SUM_W-1:0]     acc_sum,        acc_sum_next;
  logic [NSB_HI_W-1:0]  acc_nsb,        acc_nsb_next;

  logic [TYPE_W-1:0]    wtype;
  logic [SLOT_W-1:0]    word_slot;
  logic                 emit;

  assign wtype     = {1'b0, word[30:27]};
  assign word_slot = word[26:22];

  always_comb begin
    header_slot_next     = header_slot;
    header_module_next   = header_module;
    base_event_next      = base_event;
    evt_offset_next      = evt_offset;
    current_event_next   = current_event;
    latched_roc_next     = latched_roc;
    trig_time_low_next   = trig_time_low;
    trig_time_high_next  = trig_time_high;
    previous_type_next   = previous_type;
    acc_count_next       = acc_count;
    halted_next          = halted;
    acc_desc_next        = acc_desc;
    acc_time_first_next  = acc_time_first;
    acc_time_second_next = acc_time_second;
    acc_samples_next     = acc_samples;
    acc_sum_next         = acc_sum;
    acc_nsb_next         = acc_nsb;
    emit                 = 1'b0;
    res                  = '0;

    if (bank_start) begin
      header_slot_next    = '0;
      header_module_next  = '0;
      base_event_next     = first_event;
      evt_offset_next     = '0;
      current_event_next  = '0;
      latched_roc_next    = roc_id;
      trig_time_low_next  = '0;
      trig_time_high_next = '0;
      previous_type_next  = TYPE_NONE;
      acc_count_next      = ACC_IDLE;
      halted_next         = 1'b0;
    end

    if (!halted_next) begin
      if (acc_count_next != ACC_IDLE) begin
        case (acc_count_next)
          4'd1: acc_time_first_next[HALF_W-1:0]        = word[HALF_W-1:0];
          4'd2: acc_time_first_next[TIME_W-1:HALF_W]   = word[HALF_W-1:0];
          4'd3: acc_time_second_next[HALF_W-1:0]       = word[HALF_W-1:0];
          4'd4: acc_time_second_next[TIME_W-1:HALF_W]  = word[HALF_W-1:0];
          4'd5: acc_samples_next[25:0]                 = word[25:0];
          4'd6: acc_samples_next[COUNT_W-1:26]         = word[6:0];
          4'd7: acc_sum_next[29:0]                     = word[29:0];
          4'd8: acc_sum_next[SUM_W-1:30]               = word[4:0];
          4'd9: acc_nsb_next                           = word[NSB_HI_W-1:0];
          default: begin
            emit                = 1'b1;
            res.kind            = KIND_ACC;
            res.time_first      = acc_time_first;
            res.time_second     = acc_time_second;
            res.acc_descriptor  = acc_desc;
            res.sample_count    = acc_samples;
            res.sample_sum      = acc_sum;
            res.pulse_counts    = {acc_nsb, word[13:0]};
          end
        endcase
        acc_count_next = emit ? ACC_IDLE : acc_count_next + 4'd1;
      end else if (word[31]) begin
        previous_type_next = wtype;
        case (wtype)
          TYPE_BLOCK_HEADER: begin
            header_slot_next   = word_slot;
            header_module_next = word[21:18];
          end
          TYPE_BLOCK_TRAILER: begin
            if (word_slot != header_slot_next) begin
              halted_next = 1'b1;
              emit        = 1'b1;
              res.kind    = KIND_TRAILER_SLOT;
            end
          end
          TYPE_EVENT_HEADER: begin
            current_event_next = base_event_next + {{(EVT_W-IDX_W){1'b0}}, evt_offset_next};
            evt_offset_next    = evt_offset_next + 32'd1;
            emit               = 1'b1;
            if (word_slot != header_slot_next) begin
              halted_next = 1'b1;
              res.kind    = KIND_EVENT_SLOT;
            end else begin
              res.kind       = KIND_INFO;
              res.time_first = {trig_time_high_next, trig_time_low_next};
            end
          end
          TYPE_TRIG_TIME: trig_time_low_next = word[HALF_W-1:0];
          default: ;
        endcase
      end else if (previous_type_next == TYPE_TRIG_TIME) begin
        trig_time_high_next = word[HALF_W-1:0];
      end else if (previous_type_next == TYPE_ACCUM) begin
        acc_desc_next  = word[DESC_W-1:0];
        acc_count_next = 4'd1;
      end
    end

    res.evt_num    = current_event_next;
    res.source_roc = latched_roc_next;
    res.slot       = header_slot_next;
    res.mod_code   = header_module_next;
  end

  assign res_valid = in_valid && emit;
  assign status    = '{halted: halted, acc_count: acc_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      header_slot    <= '0;
      header_module  <= '0;
      base_event     <= '0;
      evt_offset     <= '0;
      current_event  <= '0;
      latched_roc    <= '0;
      trig_time_low  <= '0;
      trig_time_high <= '0;
      previous_type  <= TYPE_NONE;
      acc_count      <= ACC_IDLE;
      halted         <= 1'b0;
    end else if (in_valid) begin
      header_slot    <= header_slot_next;
      header_module  <= header_module_next;
      base_event     <= base_event_next;
      evt_offset     <= evt_offset_next;
      current_event  <= current_event_next;
      latched_roc    <= latched_roc_next;
      trig_time_low  <= trig_time_low_next;
      trig_time_high <= trig_time_high_next;
      previous_type  <= previous_type_next;
      acc_count      <= acc_count_next;
      halted         <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      acc_desc        <= acc_desc_next;
      acc_time_first  <= acc_time_first_next;
      acc_time_second <= acc_time_second_next;
      acc_samples     <= acc_samples_next;
      acc_sum         <= acc_sum_next;
      acc_nsb         <= acc_nsb_next;
    end
  end

endmodule

// ===== rtl/drwp_out_reg.sv =====
// Output result register of the readout word parser, with stream handshake.
module drwp_out_reg import drwp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

// ===== rtl/digitizer_readout_word_parser_top.sv =====
// Top level of the digitizer readout word parser.
//
// One readout word is taken in every cycle while s_tready is high; a word that completes a
// record (event header, last accumulator word or slot mismatch) shows its result on the
// master side in the cycle after it is accepted, through the output register. s_tready
// drops only while a result waits in the output register and m_tready is low.
module digitizer_readout_word_parser_top import drwp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // word [31:0], roc_id [39:32], first_event [103:40]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // bank_start [0]
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // evt_num [63:0], source_roc [71:64], slot [76:72], mod_code [80:77],
  // time_first [128:81], time_second [176:129], acc_descriptor [185:177],
  // sample_count [218:186], sample_sum [253:219], pulse_counts [295:254]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // kind [1:0]
  output logic [1:0]            m_tuser
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  status_t status;

  assign accept = s_tvalid && s_tready;

  drwp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .word        (s_tdata[31:0]),
    .bank_start  (s_tuser[0]),
    .roc_id      (s_tdata[39:32]),
    .first_event (s_tdata[103:40]),
    .res_valid   (res_valid),
    .res         (res),
    .status      (status)
  );

  drwp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tuser = out_res.kind;
  assign m_tdata = {out_res.pulse_counts, out_res.sample_sum, out_res.sample_count,
                    out_res.acc_descriptor, out_res.time_second, out_res.time_first,
                    out_res.mod_code, out_res.slot, out_res.source_roc,
                    out_res.evt_num};

  // A stalled result must hold off new requests so it cannot be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while a stalled result waits");

  // A slot mismatch halts the bank.
  a_mismatch_halts: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == KIND_TRAILER_SLOT || res.kind == KIND_EVENT_SLOT)
    |=> status.halted)
    else $error("slot mismatch did not halt the bank");

  // A halted bank produces results only once a new bank starts.
  a_halted_quiet: assert property (@(posedge clk) disable iff (rst)
    status.halted && res_valid |-> s_tuser[0])
    else $error("result produced while halted");

  // The accumulator word counter never runs past the last record word.
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    accept && status.acc_count == ACC_LAST && !s_tuser[0] |=> status.acc_count == ACC_IDLE)
    else $error("accumulator record did not close on its last word");

endmodule

// ===== dv/readout_record_checker.sv =====
// Checker that predicts the parser's output records from the accepted words and compares them.
module readout_record_checker import drwp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [1:0]            m_tuser,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  result_t expected_records[$];
  int unsigned error_count = 0;
  int unsigned pending_count = 0;

  logic [SLOT_W-1:0]    bank_slot;
  logic [MOD_W-1:0]     bank_module;
  logic [EVT_W-1:0]     bank_base;
  logic [IDX_W-1:0]     event_seq;
  logic [EVT_W-1:0]     event_now;
  logic [ROC_W-1:0]     bank_roc;
  logic [HALF_W-1:0]    trig_lo;
  logic [HALF_W-1:0]    trig_hi;
  logic [TYPE_W-1:0]    last_type;
  logic [ACC_CNT_W-1:0] acc_pos;
  logic [DESC_W-1:0]    acc_desc;
  logic [TIME_W-1:0]    acc_over_time;
  logic [TIME_W-1:0]    acc_under_time;
  logic [COUNT_W-1:0]   acc_count;
  logic [SUM_W-1:0]     acc_sum;
  logic [NSB_HI_W-1:0]  acc_overlap;
  logic                 bank_stopped;

  assign mismatches  = error_count;
  assign outstanding = pending_count;

  task automatic clear_bank();
    bank_slot      = '0;
    bank_module    = '0;
    bank_base      = '0;
    event_seq      = '0;
    event_now      = '0;
    bank_roc       = '0;
    trig_lo        = '0;
    trig_hi        = '0;
    last_type      = TYPE_NONE;
    acc_pos        = ACC_IDLE;
    acc_desc       = '0;
    acc_over_time  = '0;
    acc_under_time = '0;
    acc_count      = '0;
    acc_sum        = '0;
    acc_overlap    = '0;
    bank_stopped   = 1'b0;
  endtask

  task automatic queue_expected(input result_t r);
    expected_records.insert(expected_records.size(), r);
  endtask

  function automatic result_t record_head(input kind_t k);
    result_t r;
    r            = '0;
    r.kind       = k;
    r.evt_num    = event_now;
    r.source_roc = bank_roc;
    r.slot       = bank_slot;
    r.mod_code   = bank_module;
    return r;
  endfunction

  task automatic parse_word(input logic [WORD_W-1:0] w, input logic bs,
                            input logic [ROC_W-1:0] roc_in, input logic [EVT_W-1:0] base_in);
    result_t r;
    logic [TYPE_W-1:0] ty;
    logic [SLOT_W-1:0] sl;
    ty = {1'b0, w[30:27]};
    sl = w[26:22];
    if (bs) begin
      clear_bank();
      bank_roc  = roc_in;
      bank_base = base_in;
    end
    if (bank_stopped) return;
    // Inside an open accumulator record every word is a record word.
    if (acc_pos != ACC_IDLE) begin
      if (acc_pos == ACC_LAST) begin
        r                = record_head(KIND_ACC);
        r.time_first     = acc_over_time;
        r.time_second    = acc_under_time;
        r.acc_descriptor = acc_desc;
        r.sample_count   = acc_count;
        r.sample_sum     = acc_sum;
        r.pulse_counts   = {acc_overlap, w[13:0]};
        queue_expected(r);
        acc_pos = ACC_IDLE;
      end else begin
        case (acc_pos)
          4'd1: acc_over_time[HALF_W-1:0]       = w[HALF_W-1:0];
          4'd2: acc_over_time[TIME_W-1:HALF_W]  = w[HALF_W-1:0];
          4'd3: acc_under_time[HALF_W-1:0]      = w[HALF_W-1:0];
          4'd4: acc_under_time[TIME_W-1:HALF_W] = w[HALF_W-1:0];
          4'd5: acc_count[25:0]                 = w[25:0];
          4'd6: acc_count[32:26]                = w[6:0];
          4'd7: acc_sum[29:0]                   = w[29:0];
          4'd8: acc_sum[34:30]                  = w[4:0];
          default: acc_overlap                  = w[NSB_HI_W-1:0];
        endcase
        acc_pos = acc_pos + 4'd1;
      end
      return;
    end
    if (w[31]) begin
      last_type = ty;
      case (ty)
        TYPE_BLOCK_HEADER: begin
          bank_slot   = sl;
          bank_module = w[21:18];
        end
        TYPE_BLOCK_TRAILER: begin
          if (sl != bank_slot) begin
            bank_stopped = 1'b1;
            queue_expected(record_head(KIND_TRAILER_SLOT));
          end
        end
        TYPE_EVENT_HEADER: begin
          event_now = bank_base + EVT_W'(event_seq);
          event_seq = event_seq + 32'd1;
          if (sl != bank_slot) begin
            bank_stopped = 1'b1;
            queue_expected(record_head(KIND_EVENT_SLOT));
          end else begin
            r            = record_head(KIND_INFO);
            r.time_first = {trig_hi, trig_lo};
            queue_expected(r);
          end
        end
        TYPE_TRIG_TIME: trig_lo = w[HALF_W-1:0];
        default: ;
      endcase
    end else if (last_type == TYPE_TRIG_TIME) begin
      trig_hi = w[HALF_W-1:0];
    end else if (last_type == TYPE_ACCUM) begin
      acc_desc       = w[DESC_W-1:0];
      acc_over_time  = '0;
      acc_under_time = '0;
      acc_count      = '0;
      acc_sum        = '0;
      acc_overlap    = '0;
      acc_pos        = 4'd1;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : compare
    result_t want;
    if (rst) begin
      clear_bank();
      expected_records.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_records.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual kind %0d event %0h",
                   $time, m_tuser, m_tdata[63:0]);
        end else begin
          want = expected_records.pop_front();
          check_field("kind", 64'(want.kind), 64'(m_tuser));
          check_field("evt_num", want.evt_num, m_tdata[63:0]);
          check_field("source_roc", 64'(want.source_roc), 64'(m_tdata[71:64]));
          check_field("slot", 64'(want.slot), 64'(m_tdata[76:72]));
          check_field("mod_code", 64'(want.mod_code), 64'(m_tdata[80:77]));
          check_field("time_first", 64'(want.time_first), 64'(m_tdata[128:81]));
          check_field("time_second", 64'(want.time_second), 64'(m_tdata[176:129]));
          check_field("acc_descriptor", 64'(want.acc_descriptor), 64'(m_tdata[185:177]));
          check_field("sample_count", 64'(want.sample_count), 64'(m_tdata[218:186]));
          check_field("sample_sum", 64'(want.sample_sum), 64'(m_tdata[253:219]));
          check_field("pulse_counts", 64'(want.pulse_counts), 64'(m_tdata[295:254]));
        end
      end
      if (s_tvalid && s_tready) begin
        parse_word(s_tdata[31:0], s_tuser[0], s_tdata[39:32], s_tdata[103:40]);
      end
    end
    pending_count = expected_records.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Testbench top that feeds readout banks to the word parser and reports the verdict.
module testbench import drwp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1450;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 29;
  localparam int SETTLE       = 10;
  localparam logic [TYPE_W-1:0] TYPE_SPARE = 5'd15;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [0:0]            s_tuser  = '0;
  logic                  m_tready = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  int unsigned           mismatches;
  int unsigned           outstanding;
  int unsigned           words_parsed = 0;
  bit                    steady       = 1'b0;
  bit                    hold_request = 1'b0;
  bit                    bank_halted  = 1'b0;

  always #1 clk = ~clk;

  digitizer_readout_word_parser_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  readout_record_checker record_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    #200_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic offer(input logic [WORD_W-1:0] w, input logic bs,
                       input logic [ROC_W-1:0] roc, input logic [EVT_W-1:0] base);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {base, roc, w};
    s_tuser  <= bs;
    if (bs) bank_halted = 1'b0;
    if (!bank_halted) words_parsed++;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_word(input logic [WORD_W-1:0] w);
    offer(w, 1'b0, ROC_W'($urandom), {$urandom, $urandom});
  endtask

  function automatic logic [WORD_W-1:0] type_word(input logic [TYPE_W-1:0] ty,
                                                  input logic [SLOT_W-1:0] sl);
    return {1'b1, ty[3:0], sl, 22'($urandom)};
  endfunction

  function automatic logic [WORD_W-1:0] header_word(input logic [SLOT_W-1:0] sl,
                                                    input logic [MOD_W-1:0] md);
    return {1'b1, TYPE_BLOCK_HEADER[3:0], sl, md, 18'($urandom)};
  endfunction

  // The first word opens the record, so its type bit must be clear.
  task automatic send_record(input int n_words);
    send_word({1'b0, 31'($urandom)});
    repeat (n_words - 1) send_word($urandom);
  endtask

  task automatic send_noise();
    logic [TYPE_W-1:0] ty;
    ty = TYPE_W'($urandom_range(4, 14));
    if (ty >= TYPE_ACCUM) ty = ty + 5'd1;
    case ($urandom_range(0, 2))
      0: begin
        send_word(type_word(ty, SLOT_W'($urandom)));
        repeat ($urandom_range(0, 2)) send_word({1'b0, 31'($urandom)});
      end
      1: begin
        send_word(type_word(TYPE_ACCUM, SLOT_W'($urandom)));
        send_word(type_word(ty, SLOT_W'($urandom)));
      end
      default: send_word({1'b0, 31'($urandom)});
    endcase
  endtask

  task automatic random_bank();
    logic [SLOT_W-1:0] sl;
    logic [EVT_W-1:0]  base;
    int                pick;
    sl   = SLOT_W'($urandom);
    base = ($urandom_range(0, 9) == 0) ? ~EVT_W'($urandom_range(0, 3)) : {$urandom, $urandom};
    offer(header_word(sl, MOD_W'($urandom)), 1'b1, ROC_W'($urandom), base);
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 99) < 70) begin
        send_word(type_word(TYPE_TRIG_TIME, SLOT_W'($urandom)));
        send_word({1'b0, 31'($urandom)});
      end
      pick = $urandom_range(0, 99);
      send_word(type_word(TYPE_EVENT_HEADER, (pick < 3) ? sl ^ SLOT_W'($urandom_range(1, 31)) : sl));
      if (pick < 3) bank_halted = 1'b1;
      if ($urandom_range(0, 99) < 50) begin
        send_word(type_word(TYPE_ACCUM, SLOT_W'($urandom)));
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(0, 99) < 6) begin
            send_record($urandom_range(1, 10));
            return;
          end
          send_record(11);
        end
      end
      if ($urandom_range(0, 99) < 15) send_noise();
    end
    pick = $urandom_range(0, 99);
    send_word(type_word(TYPE_BLOCK_TRAILER, (pick < 4) ? sl ^ SLOT_W'($urandom_range(1, 31)) : sl));
    if (pick < 4) bank_halted = 1'b1;
  endtask

  task automatic run_directed();
    send_word({1'b0, 31'h7FFF_FFFF});
    offer(header_word(5'h1F, 4'hF), 1'b1, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(type_word(TYPE_ACCUM, 5'h1F));
    send_word(32'h7FFF_FFFF);
    repeat (10) send_word(32'hFFFF_FFFF);
    send_word({1'b1, TYPE_TRIG_TIME[3:0], 27'h7FF_FFFF});
    send_word(32'h00FF_FFFF);
    repeat (2) send_word(type_word(TYPE_EVENT_HEADER, 5'h1F));
    send_word(type_word(TYPE_SPARE, 5'h1F));
    send_word(32'h0000_0000);
    send_word(type_word(TYPE_BLOCK_TRAILER, 5'h1F));
    offer({1'b1, TYPE_BLOCK_HEADER[3:0], 27'h0}, 1'b1, 8'h00, 64'h0);
    send_word(type_word(TYPE_BLOCK_TRAILER, 5'd5));
    bank_halted = 1'b1;
    send_word(type_word(TYPE_EVENT_HEADER, 5'd0));
    offer(header_word(5'd3, 4'd2), 1'b1, ROC_W'($urandom), {$urandom, $urandom});
    send_word(type_word(TYPE_EVENT_HEADER, 5'd4));
    bank_halted = 1'b1;
    offer(header_word(5'd9, 4'd6), 1'b1, ROC_W'($urandom), {$urandom, $urandom});
    send_word(type_word(TYPE_ACCUM, 5'd9));
    send_word(32'h0000_0000);
    repeat (3) send_word(32'h0000_0000);
    offer(header_word(5'd9, 4'd6), 1'b1, ROC_W'($urandom), {$urandom, $urandom});
    send_word(type_word(TYPE_EVENT_HEADER, 5'd9));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    hold_request = 1'b1;
    while (words_parsed < 500) random_bank();
    drain();
    steady = 1'b1;
    while (words_parsed < 850) random_bank();
    steady = 1'b0;
    while (words_parsed < ITEM_TARGET) random_bank();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
